@@ rtl/swa_pkg.sv @@
// ----------------------------------------------------------------------------
// swa_pkg
// Shared constants and the command/status bundles that pass between the
// sliding window average controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package swa_pkg;

    // default configuration
    localparam int DEF_WINDOW      = 128;
    localparam int DEF_SAMPLE_BITS = 12;

    // fixed port widths
    localparam int IN_BITS  = 12;
    localparam int AVG_BITS = 12;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;     // item taken: write store, read oldest entry
        logic update;     // fold sample into sum, advance position and count
        logic div_step;   // one restoring divide step
        logic out_load;   // move quotient into the output register
    } swa_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;   // output register empty or being drained this cycle
    } swa_stat_t;

endpackage

`default_nettype wire

@@ rtl/swa_ctrl.sv @@
// ----------------------------------------------------------------------------
// swa_ctrl
// Sequencer for the sliding window average: accept, update, a bit-serial
// divide of SUM_BITS steps, then hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_ctrl
    import swa_pkg::*;
#(
    parameter int SUM_BITS = DEF_SAMPLE_BITS + $clog2(DEF_WINDOW + 1)
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output swa_cmd_t       cmd,
    input  wire swa_stat_t stat
);

    localparam int CNT_BITS = $clog2(SUM_BITS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_UPD  = 4'b0010,
        S_DIV  = 4'b0100,
        S_HOLD = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                div_last;

    assign div_last = (cnt_reg == CNT_BITS'(SUM_BITS - 1));
    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (div_last)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/swa_dpath.sv @@
// ----------------------------------------------------------------------------
// swa_dpath
// Sample store, running sum, write position, fill count, restoring divider
// and output register of the sliding window average.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_dpath
    import swa_pkg::*;
#(
    parameter int WINDOW      = DEF_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW + 1)
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire swa_cmd_t            cmd,
    output swa_stat_t                stat,
    input  wire logic [IN_BITS-1:0]  sample,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [AVG_BITS-1:0]      average_level,
    output logic                     window_full
);

    localparam int POS_BITS = $clog2(WINDOW);
    localparam int FILL_BITS = $clog2(WINDOW + 1);

    logic [SAMPLE_BITS-1:0] store_mem [WINDOW];
    logic [SAMPLE_BITS-1:0] old_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic [SAMPLE_BITS-1:0] old_val;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [POS_BITS-1:0]    pos_reg;
    logic [FILL_BITS-1:0]   fill_reg;
    logic                   full;
    logic [SUM_BITS-1:0]    quo_reg;
    logic [FILL_BITS-1:0]   rem_reg;
    logic [FILL_BITS:0]     rem_shift;
    logic                   rem_ge;
    logic [FILL_BITS-1:0]   rem_next;
    logic                   out_valid_reg;
    logic [AVG_BITS-1:0]    avg_reg;
    logic                   full_reg;

    assign full = (fill_reg == FILL_BITS'(WINDOW));

    // store: read-first, oldest entry comes out as the new one goes in
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            old_reg            <= store_mem[pos_reg];
            store_mem[pos_reg] <= SAMPLE_BITS'(sample);
            smp_reg            <= SAMPLE_BITS'(sample);
        end
    end

    // entries not yet written count as zero until the window has filled
    assign old_val  = full ? old_reg : '0;
    assign sum_next = sum_reg - SUM_BITS'(old_val) + SUM_BITS'(smp_reg);

    // running sum, position and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else if (cmd.update)
        begin
            sum_reg <= sum_next;
            if (pos_reg == POS_BITS'(WINDOW - 1))
            begin
                pos_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (!full)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // restoring divide step, one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[SUM_BITS-1]};
    assign rem_ge    = (rem_shift >= {1'b0, fill_reg});
    assign rem_next  = rem_ge ? FILL_BITS'(rem_shift - {1'b0, fill_reg})
                              : FILL_BITS'(rem_shift);

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            quo_reg <= sum_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[SUM_BITS-2:0], rem_ge};
            rem_reg <= rem_next;
        end
    end

    // output register
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            avg_reg  <= AVG_BITS'(quo_reg);
            full_reg <= full;
        end
    end

    assign out_valid     = out_valid_reg;
    assign average_level = avg_reg;
    assign window_full   = full_reg;

endmodule

`default_nettype wire

@@ rtl/sliding_window_average.sv @@
// ----------------------------------------------------------------------------
// sliding_window_average
// Boxcar moving average over the last WINDOW samples with a running sum and
// a truncated mean, plus a flag once the window has filled.
// ----------------------------------------------------------------------------
//  channel  | signals                         | direction
//  ---------+---------------------------------+----------
//  input    | in_valid, in_ready, sample      | in
//  output   | out_valid, out_ready,           | out
//           | average_level, window_full      |
//
//  an item goes from acceptance to result through the update state, the
//  bit-serial restoring divider with one step per quotient bit, and the
//  load into the output register
//  in_ready returns as the result is loaded, so a new item is taken only
//  after the previous result has been loaded; a result waiting on
//  out_ready does not block the next item
//  reset needs no clearing pass: the oldest entry counts as zero until the
//  fill count reaches WINDOW, so the store itself is never cleared
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_average
    import swa_pkg::*;
#(
    parameter int WINDOW      = DEF_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [IN_BITS-1:0]  sample,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [AVG_BITS-1:0]      average_level,
    output logic                     window_full
);

    localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW + 1);

    swa_cmd_t  cmd;
    swa_stat_t stat;

    // controller
    swa_ctrl #(
        .SUM_BITS (SUM_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // datapath
    swa_dpath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .average_level (average_level),
        .window_full   (window_full)
    );

    // one item at a time: after an accept the input side closes
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after an accept");

    // the mean never exceeds the largest sample value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((average_level >> SAMPLE_BITS) == '0))
    else $error("average wider than a sample");

    // once full, the window stays full
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && window_full) |=> window_full)
    else $error("window_full dropped");

    // a result never appears while the input side is open and nothing pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && in_ready) |=> !out_valid)
    else $error("result without an item");

endmodule

`default_nettype wire
